FILE: sv/ril_pkg.sv
// Shared types and constants for the rotating id list.
// Used by ril_cell and rotating_id_list_top; depends on nothing else.
`default_nettype none

package ril_pkg;

    // Table geometry
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ID_BITS = 32;

    // Number of cell write ports broadcast per operation
    localparam int WR_PORTS = 3;

    // Operation codes
    localparam logic [1:0] K_ADD    = 2'd0;
    localparam logic [1:0] K_REMOVE = 2'd1;
    localparam logic [1:0] K_ROTATE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

    // Input request
    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_BITS-1:0] item_id;
        logic [SLOT_W-1:0]  slot_handle;
    } t_in;

    // Result
    typedef struct packed {
        logic [SLOT_W-1:0]  result_handle;
        logic [ID_BITS-1:0] result_id;
        logic [1:0]         status;
        logic [CNT_W-1:0]   entry_count;
    } t_out;

    // One slot's contents as seen from outside the cell
    typedef struct packed {
        logic               used;
        logic               hf;     // has link toward front
        logic               hb;     // has link toward back
        logic [SLOT_W-1:0]  tf;     // link toward front
        logic [SLOT_W-1:0]  tb;     // link toward back
        logic [ID_BITS-1:0] id;
    } t_cell_state;

    // Field update broadcast to the row; the cell whose index matches applies it
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  idx;
        logic               set_used;
        logic               used;
        logic               set_hf;
        logic               hf;
        logic               set_hb;
        logic               hb;
        logic               set_tf;
        logic [SLOT_W-1:0]  tf;
        logic               set_tb;
        logic [SLOT_W-1:0]  tb;
        logic               set_id;
        logic [ID_BITS-1:0] id;
    } t_cell_wr;

endpackage

`default_nettype wire

FILE: sv/ril_cell.sv
// One slot of the rotating id list: id, both links and their flags.
// Also one link of the free-slot priority chain. Depends on ril_pkg.
`default_nettype none

module ril_cell (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [ril_pkg::SLOT_W-1:0]            i_index,
    input  wire ril_pkg::t_cell_wr [ril_pkg::WR_PORTS-1:0] i_wr,
    input  wire logic                                  i_free_below,
    output logic                                       o_free_below,
    output logic                                       o_grant,
    output ril_pkg::t_cell_state                       o_state
);
    import ril_pkg::*;

    logic               r_used, n_used;
    logic               r_hf, n_hf;
    logic               r_hb, n_hb;
    logic [SLOT_W-1:0]  r_tf, n_tf;
    logic [SLOT_W-1:0]  r_tb, n_tb;
    logic [ID_BITS-1:0] r_id, n_id;

    // Apply matching write ports in port order; later ports win per field
    always_comb begin
        n_used = r_used;
        n_hf   = r_hf;
        n_hb   = r_hb;
        n_tf   = r_tf;
        n_tb   = r_tb;
        n_id   = r_id;
        for (int k = 0; k < WR_PORTS; k++) begin
            if (i_wr[k].en && (i_wr[k].idx == i_index)) begin
                if (i_wr[k].set_used) n_used = i_wr[k].used;
                if (i_wr[k].set_hf)   n_hf   = i_wr[k].hf;
                if (i_wr[k].set_hb)   n_hb   = i_wr[k].hb;
                if (i_wr[k].set_tf)   n_tf   = i_wr[k].tf;
                if (i_wr[k].set_tb)   n_tb   = i_wr[k].tb;
                if (i_wr[k].set_id)   n_id   = i_wr[k].id;
            end
        end
    end

    // Flags: cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_hf   <= 1'b0;
            r_hb   <= 1'b0;
        end else begin
            r_used <= n_used;
            r_hf   <= n_hf;
            r_hb   <= n_hb;
        end
    end

    // Payload: only read while a flag covers it
    always_ff @(posedge i_clk) begin
        r_tf <= n_tf;
        r_tb <= n_tb;
        r_id <= n_id;
    end

    // Free-slot chain: lowest free cell takes the grant
    assign o_free_below = i_free_below | ~r_used;
    assign o_grant      = ~r_used & ~i_free_below;

    assign o_state = '{used: r_used, hf: r_hf, hb: r_hb,
                       tf: r_tf, tb: r_tb, id: r_id};

endmodule

`default_nettype wire

FILE: sv/rotating_id_list_top.sv
// Top level of the rotating id list: request capture, operation sequencer,
// row of ril_cell slots and the output register. Depends on ril_pkg, ril_cell.
//
//  channel   direction  handshake                payload
//  in        request    i_in_valid / o_in_stall  i_in_data  (t_in)
//  out       result     o_out_valid / i_out_stall o_out_data (t_out)
//
// Each request is first captured, then in the execute state the addressed slot
// is read from the cell row and the link updates are broadcast to the cells.
// The execute state waits while a previous result held in the output register
// is stalled; a new request is taken once the sequencer is back in idle.
// Synchronous active-low reset clears all in-use and link flags at once.
`default_nettype none

module rotating_id_list_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire ril_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output ril_pkg::t_out       o_out_data
);
    import ril_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state             r_state, n_state;
    t_in                r_req;
    logic [SLOT_W-1:0]  r_front, n_front;
    logic [SLOT_W-1:0]  r_back, n_back;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid;
    t_out               r_out;

    t_cell_wr [WR_PORTS-1:0] w_wr;
    t_cell_wr [WR_PORTS-1:0] w_wr_gated;
    t_cell_state             w_state [SLOTS];
    logic [SLOTS:0]          w_chain;
    logic [SLOTS-1:0]        w_grant;
    logic [SLOTS-1:0]        w_used_vec;
    t_cell_state             w_rd;
    logic [SLOT_W-1:0]       w_rd_idx;
    logic [SLOT_W-1:0]       w_free_idx;
    logic                    w_full;
    logic                    w_fire;
    logic                    w_accept;
    t_out                    w_res;

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // Cell row with free-slot chain
    assign w_chain[0] = 1'b0;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ril_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (SLOT_W'(g)),
            .i_wr         (w_wr_gated),
            .i_free_below (w_chain[g]),
            .o_free_below (w_chain[g+1]),
            .o_grant      (w_grant[g]),
            .o_state      (w_state[g])
        );
        assign w_used_vec[g] = w_state[g].used;
    end

    assign w_full = ~w_chain[SLOTS];

    // Encode granted free slot (grant is one-hot or zero)
    always_comb begin
        w_free_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_grant[i]) w_free_idx = w_free_idx | SLOT_W'(i);
        end
    end

    // Read port: removed slot or current front
    assign w_rd_idx = (r_req.kind == K_REMOVE) ? r_req.slot_handle : r_front;

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (SLOT_W'(i) == w_rd_idx) w_rd = w_state[i];
        end
    end

    // Operation decode: result, pointer updates and cell writes
    always_comb begin
        w_wr    = '0;
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        w_res   = '0;
        unique case (r_req.kind)
            K_ADD: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_wr[0].en       = 1'b1;
                    w_wr[0].idx      = w_free_idx;
                    w_wr[0].set_used = 1'b1;
                    w_wr[0].used     = 1'b1;
                    w_wr[0].set_id   = 1'b1;
                    w_wr[0].id       = r_req.item_id;
                    w_wr[0].set_hb   = 1'b1;
                    w_wr[0].hb       = 1'b0;
                    w_wr[0].set_hf   = 1'b1;
                    w_wr[0].hf       = (r_count != '0);
                    w_wr[0].set_tf   = (r_count != '0);
                    w_wr[0].tf       = r_back;
                    // old back points to the new entry
                    w_wr[1].en       = (r_count != '0);
                    w_wr[1].idx      = r_back;
                    w_wr[1].set_tb   = 1'b1;
                    w_wr[1].tb       = w_free_idx;
                    w_wr[1].set_hb   = 1'b1;
                    w_wr[1].hb       = 1'b1;
                    if (r_count == '0) n_front = w_free_idx;
                    n_back  = w_free_idx;
                    n_count = r_count + CNT_W'(1);
                    w_res.result_handle = w_free_idx;
                end
            end
            K_REMOVE: begin
                if (r_count == '0) begin
                    w_res.status = ST_EMPTY;
                end else if (!w_rd.used) begin
                    w_res.status = ST_NOT_IN_USE;
                end else begin
                    w_wr[0].idx = w_rd.tf;
                    w_wr[1].idx = w_rd.tb;
                    priority if (w_rd.hf && w_rd.hb) begin
                        // middle entry: join the neighbors
                        w_wr[0].en     = 1'b1;
                        w_wr[0].set_tb = 1'b1;
                        w_wr[0].tb     = w_rd.tb;
                        w_wr[1].en     = 1'b1;
                        w_wr[1].set_tf = 1'b1;
                        w_wr[1].tf     = w_rd.tf;
                    end else if (w_rd.hb) begin
                        // front entry: next one becomes front
                        w_wr[1].en     = 1'b1;
                        w_wr[1].set_hf = 1'b1;
                        w_wr[1].hf     = 1'b0;
                        n_front        = w_rd.tb;
                    end else if (w_rd.hf) begin
                        // back entry: previous one becomes back
                        w_wr[0].en     = 1'b1;
                        w_wr[0].set_hb = 1'b1;
                        w_wr[0].hb     = 1'b0;
                        n_back         = w_rd.tf;
                    end else begin
                        n_front = '0;
                        n_back  = '0;
                    end
                    w_wr[2].en       = 1'b1;
                    w_wr[2].idx      = r_req.slot_handle;
                    w_wr[2].set_used = 1'b1;
                    w_wr[2].used     = 1'b0;
                    w_wr[2].set_hf   = 1'b1;
                    w_wr[2].hf       = 1'b0;
                    w_wr[2].set_hb   = 1'b1;
                    w_wr[2].hb       = 1'b0;
                    n_count = r_count - CNT_W'(1);
                end
            end
            K_ROTATE: begin
                if (r_count == '0) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_res.result_id = w_rd.id;
                    if (r_count != CNT_W'(1)) begin
                        // next entry becomes front
                        w_wr[0].en     = 1'b1;
                        w_wr[0].idx    = w_rd.tb;
                        w_wr[0].set_hf = 1'b1;
                        w_wr[0].hf     = 1'b0;
                        // old front moves behind the back
                        w_wr[1].en     = 1'b1;
                        w_wr[1].idx    = r_front;
                        w_wr[1].set_tf = 1'b1;
                        w_wr[1].tf     = r_back;
                        w_wr[1].set_hf = 1'b1;
                        w_wr[1].hf     = 1'b1;
                        w_wr[1].set_hb = 1'b1;
                        w_wr[1].hb     = 1'b0;
                        w_wr[2].en     = 1'b1;
                        w_wr[2].idx    = r_back;
                        w_wr[2].set_tb = 1'b1;
                        w_wr[2].tb     = r_front;
                        w_wr[2].set_hb = 1'b1;
                        w_wr[2].hb     = 1'b1;
                        n_front = w_rd.tb;
                        n_back  = r_front;
                    end
                end
            end
            default: begin
                // unused kind: no operation
            end
        endcase
        w_res.entry_count = n_count;
    end

    // Writes reach the cells only on the completing cycle
    always_comb begin
        w_wr_gated = w_wr;
        for (int k = 0; k < WR_PORTS; k++) begin
            w_wr_gated[k].en = w_wr[k].en & w_fire;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  if (w_fire)     n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_front     <= n_front;
                r_back      <= n_back;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) r_req <= i_in_data;
        if (w_fire)   r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_used_vec) == int'(r_count))
        else $error("entry count differs from slots in use");

    a_ends_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (w_used_vec[r_front] && w_used_vec[r_back]))
        else $error("front or back slot not in use");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("completed request did not load the output register");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for rotating_id_list_top: directed table, then random phases.
// Needs ril_pkg and the rotating_id_list_top RTL; checks results against a built-in list model.
`timescale 1ns / 1ps

module testbench;
    import ril_pkg::*;

    // Kind value three has no operation behind it
    localparam logic [1:0] K_UNUSED = 2'd3;

    // Directed rows: expected result typed in, or taken from the list model
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam int RANDOM_OPS   = 1675;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out want;
    } t_row;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_CHURN} t_phase;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out_data;

    rotating_id_list_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // List model: slot table with links toward front and toward back
    // ------------------------------------------------------------------
    logic [ID_BITS-1:0] stored_id [SLOTS];
    logic [SLOT_W-1:0]  link_fwd  [SLOTS];
    logic [SLOT_W-1:0]  link_bwd  [SLOTS];
    logic               fwd_ok    [SLOTS];
    logic               bwd_ok    [SLOTS];
    logic [SLOTS-1:0]   occupied;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic [CNT_W-1:0]   live_count;

    t_out pending_results [$];

    task automatic list_reset();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            stored_id[i] = '0;
            link_fwd[i]  = '0;
            link_bwd[i]  = '0;
            fwd_ok[i]    = 1'b0;
            bwd_ok[i]    = 1'b0;
        end
        occupied   = '0;
        head_slot  = '0;
        tail_slot  = '0;
        live_count = '0;
    endtask

    // Applies one request to the model and returns the result it produces
    function automatic t_out list_apply(input t_in req);
        t_out              res;
        int                i;
        int                free_slot;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] f;
        logic [SLOT_W-1:0] b;
        res        = '0;
        res.status = ST_OK;
        case (req.kind)
            K_ADD: begin
                free_slot = -1;
                for (i = SLOTS - 1; i >= 0; i--) begin
                    if (!occupied[i]) free_slot = i;
                end
                if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    s = SLOT_W'(free_slot);
                    occupied[s]  = 1'b1;
                    stored_id[s] = req.item_id;
                    bwd_ok[s]    = 1'b0;
                    if (live_count == 0) begin
                        fwd_ok[s] = 1'b0;
                        head_slot = s;
                    end else begin
                        link_fwd[s]         = tail_slot;
                        fwd_ok[s]           = 1'b1;
                        link_bwd[tail_slot] = s;
                        bwd_ok[tail_slot]   = 1'b1;
                    end
                    tail_slot         = s;
                    live_count        = live_count + 1'b1;
                    res.result_handle = s;
                end
            end
            K_REMOVE: begin
                s = req.slot_handle;
                if (live_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (!occupied[s]) begin
                    res.status = ST_NOT_IN_USE;
                end else begin
                    f = link_fwd[s];
                    b = link_bwd[s];
                    if (fwd_ok[s] && bwd_ok[s]) begin
                        link_bwd[f] = b;
                        link_fwd[b] = f;
                    end else if (bwd_ok[s]) begin
                        fwd_ok[b] = 1'b0;
                        head_slot = b;
                    end else if (fwd_ok[s]) begin
                        bwd_ok[f] = 1'b0;
                        tail_slot = f;
                    end else begin
                        head_slot = '0;
                        tail_slot = '0;
                    end
                    occupied[s] = 1'b0;
                    fwd_ok[s]   = 1'b0;
                    bwd_ok[s]   = 1'b0;
                    live_count  = live_count - 1'b1;
                end
            end
            K_ROTATE: begin
                if (live_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.result_id = stored_id[head_slot];
                    // a single entry stays where it is
                    if (live_count > 1) begin
                        s = head_slot;
                        b = link_bwd[s];
                        fwd_ok[b]           = 1'b0;
                        head_slot           = b;
                        link_fwd[s]         = tail_slot;
                        fwd_ok[s]           = 1'b1;
                        bwd_ok[s]           = 1'b0;
                        link_bwd[tail_slot] = s;
                        bwd_ok[tail_slot]   = 1'b1;
                        tail_slot           = s;
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = live_count;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    function automatic t_row mk_row(input logic [1:0] kind, input logic [ID_BITS-1:0] id,
                                    input logic [SLOT_W-1:0] handle, input logic typed,
                                    input logic [SLOT_W-1:0] w_handle,
                                    input logic [ID_BITS-1:0] w_id,
                                    input logic [1:0] w_status,
                                    input logic [CNT_W-1:0] w_count);
        t_row r;
        r.req.kind              = kind;
        r.req.item_id           = id;
        r.req.slot_handle       = handle;
        r.typed                 = typed;
        r.want.result_handle    = w_handle;
        r.want.result_id        = w_id;
        r.want.status           = w_status;
        r.want.entry_count      = w_count;
        return r;
    endfunction

    // Remove target: mostly live slots (front, back, anywhere), some random handles
    function automatic logic [SLOT_W-1:0] removal_target();
        int                roll;
        int                i;
        int                start;
        logic              found;
        logic [SLOT_W-1:0] pick;
        roll  = $urandom_range(0, 99);
        pick  = SLOT_W'($urandom_range(0, SLOTS - 1));
        found = 1'b0;
        if (live_count != 0 && roll < 15) begin
            pick = head_slot;
        end else if (live_count != 0 && roll < 30) begin
            pick = tail_slot;
        end else if (live_count != 0 && roll < 90) begin
            start = $urandom_range(0, SLOTS - 1);
            for (i = 0; i < SLOTS; i++) begin
                if (!found && occupied[(start + i) % SLOTS]) begin
                    pick  = SLOT_W'((start + i) % SLOTS);
                    found = 1'b1;
                end
            end
        end
        return pick;
    endfunction

    function automatic t_in next_request(input t_phase phase);
        t_in req;
        int  roll;
        int  add_pct;
        int  rem_pct;
        case (phase)
            PH_FILL:  begin add_pct = 80; rem_pct = 10; end
            PH_DRAIN: begin add_pct = 10; rem_pct = 72; end
            default:  begin add_pct = 34; rem_pct = 34; end
        endcase
        req.item_id     = $urandom();
        req.slot_handle = SLOT_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 9) == 0) begin
            req.item_id = $urandom_range(0, 1) ? '1 : '0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            req.kind = K_UNUSED;
        end else if (roll < 2 + add_pct) begin
            req.kind = K_ADD;
        end else if (roll < 2 + add_pct + rem_pct) begin
            req.kind        = K_REMOVE;
            req.slot_handle = removal_target();
        end else begin
            req.kind = K_ROTATE;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int kind_seen [4];
    int peak_count = 0;

    task automatic issue(input t_in req, input logic typed, input t_out want);
        int   gap;
        t_out predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        burst_left = burst_left - 1;
        predicted  = list_apply(req);
        pending_results.push_back(typed ? want : predicted);
        kind_seen[req.kind]++;
        if (live_count > peak_count) peak_count = live_count;
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern changes mode every so often
    // ------------------------------------------------------------------
    t_rx_mode rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_tick      = 0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 75);
            default:  i_out_stall <= ((rx_tick % 7) < 4);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    int   error_count = 0;
    int   status_seen [4];
    t_out oldest_result;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: %p", o_out_data);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                status_seen[oldest_result.status]++;
                if (o_out_data.result_handle !== oldest_result.result_handle) begin
                    $error("result_handle: expected %0d, got %0d",
                           oldest_result.result_handle, o_out_data.result_handle);
                    error_count++;
                end
                if (o_out_data.result_id !== oldest_result.result_id) begin
                    $error("result_id: expected 0x%08h, got 0x%08h",
                           oldest_result.result_id, o_out_data.result_id);
                    error_count++;
                end
                if (o_out_data.status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.entry_count !== oldest_result.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           oldest_result.entry_count, o_out_data.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long with no request and no result moving
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_results.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_row plan [$];

    initial begin
        int     ops_done;
        int     k;
        int     phase_len;
        t_phase phase;
        t_in    req;

        list_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //                 kind      item_id       handle typed      w_hdl  w_id      status  count
        plan.push_back(mk_row(K_ROTATE, 32'h0,        6'd0,  TYPED, 6'd0, 32'h0, ST_EMPTY, 7'd0));
        plan.push_back(mk_row(K_REMOVE, 32'h0,        6'd63, TYPED, 6'd0, 32'h0, ST_EMPTY, 7'd0));
        plan.push_back(mk_row(K_UNUSED, 32'hFFFF_FFFF, 6'd63, TYPED, 6'd0, 32'h0, ST_OK, 7'd0));
        plan.push_back(mk_row(K_ADD,    32'hFFFF_FFFF, 6'd0,  TYPED, 6'd0, 32'h0, ST_OK, 7'd1));
        // single entry rotates onto itself
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, TYPED, 6'd0, 32'hFFFF_FFFF, ST_OK, 7'd1));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd63, TYPED, 6'd0, 32'h0, ST_NOT_IN_USE, 7'd1));
        plan.push_back(mk_row(K_ADD,    32'h0,         6'd63, TYPED, 6'd1, 32'h0, ST_OK, 7'd2));
        plan.push_back(mk_row(K_ADD,    32'hA5A5_5A5A, 6'd0,  TYPED, 6'd2, 32'h0, ST_OK, 7'd3));
        plan.push_back(mk_row(K_ADD,    32'h8000_0001, 6'd0,  TYPED, 6'd3, 32'h0, ST_OK, 7'd4));
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, TYPED, 6'd0, 32'hFFFF_FFFF, ST_OK, 7'd4));
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, TYPED, 6'd0, 32'h0,         ST_OK, 7'd4));
        // order now 2,3,0,1: remove middle, front, back, then refill and rotate
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd3, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd2, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd1, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_ADD, 32'h1234_5678, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        // last entry leaves, then an empty remove
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd1, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd0, TYPED, 6'd0, 32'h0, ST_EMPTY, 7'd0));
        plan.push_back(mk_row(K_ADD, 32'h0000_FFFF, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_ADD, 32'hFFFF_0000, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_UNUSED, 32'h0, 6'd0, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_REMOVE, 32'h0, 6'd40, PREDICTED, '0, '0, ST_OK, '0));
        plan.push_back(mk_row(K_ROTATE, 32'h0, 6'd0, PREDICTED, '0, '0, ST_OK, '0));

        foreach (plan[k]) issue(plan[k].req, plan[k].typed, plan[k].want);
        wait_drained();

        // Random phases; the first one fills the table past full
        ops_done  = 0;
        phase     = PH_FILL;
        phase_len = 150;
        while (ops_done < RANDOM_OPS) begin
            for (k = 0; k < phase_len && ops_done < RANDOM_OPS; k++) begin
                req = next_request(phase);
                issue(req, PREDICTED, '0);
                if (req.kind != K_UNUSED) ops_done++;
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
            phase     = t_phase'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 160);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d add, %0d remove, %0d rotate, %0d unused kind; peak entries %0d",
                 kind_seen[K_ADD], kind_seen[K_REMOVE], kind_seen[K_ROTATE],
                 kind_seen[K_UNUSED], peak_count);
        $display("results: %0d ok, %0d empty, %0d full, %0d slot not in use; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_NOT_IN_USE], error_count);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
